// File: sv/rpdjt_pkg.sv
// Shared constants, widths, register codes and sequencer states for the ramped PD torque block.
package rpdjt_pkg;

  // Joint count per control tick; the counter advances on the last joint
  localparam int unsigned NumJoints = 16;
  localparam logic [3:0]  LastIdx   = 4'((NumJoints - 1) % 16);
  localparam int unsigned RampStepsDefault = 1000;

  // Datapath widths
  localparam int unsigned MulAW = 34;              // signed operand
  localparam int unsigned MulBW = 17;              // signed operand, always non-negative
  localparam int unsigned ProdW = MulAW + MulBW;   // signed product
  localparam int unsigned SumW  = ProdW + 1;       // torque accumulator, 24 fraction bits
  localparam int unsigned TauW  = SumW - 8;        // torque after reduction to Q16.16

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgKpGains    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKdGains    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLegTargets = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgJointSigns = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgJointLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgWheelLimit = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgWheelMask  = 3'd6;

  // Register reset values
  localparam logic [30:0] JointLimitRst = 31'd2293760;   // 35.0
  localparam logic [30:0] WheelLimitRst = 31'd13107200;  // 200.0
  localparam logic [15:0] WheelMaskRst  = 16'h2108;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAMP,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_KP,
    ST_KD,
    ST_SUM,
    ST_CLIP
  } state_e;

endpackage

// File: sv/ramped_pd_joint_torque.sv
// Top level: PD joint torque with gravity feedforward and a linear setpoint ramp.
//
// One joint sample enters on the input channel (valid/stall) and one torque word
// leaves on the output channel. A small sequencer drives one shared 34x17 signed
// multiplier three times per word (ramp step, Kp term, Kd term) and, while the
// ramp is running, a reciprocal-multiply divider by RAMP_STEPS for the setpoint.
// Each word walks the states RAMP (ramp product), DIVGO and DIVWAIT (divider,
// only while the ramp runs), KP, KD, SUM and CLIP. The divider is DivW = 34 +
// counter width bits wide, 44 at the default RAMP_STEPS, and works one 16-bit
// digit at a time. The input stalls while a word is in work, so a new sample is
// taken only once the sequencer is back in IDLE. The result sits in an output
// register: a stalled receiver holds it there, and the next sample is taken
// meanwhile; the sequencer waits at its last step only if the output register
// is still full and its receiver stalls.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i) and
// must only be written while the block is idle. Reset clears the registers to
// their defaults, the ramp counter and every start position to zero.
module ramped_pd_joint_torque #(
  parameter int unsigned RAMP_STEPS = rpdjt_pkg::RampStepsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpdjt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [3:0]                    joint_index_i,
  input  logic                          enter_stance_i,
  input  logic signed [31:0]            measured_position_i,
  input  logic signed [31:0]            measured_velocity_i,
  input  logic signed [31:0]            gravity_torque_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            torque_command_o,
  output logic                          limited_o
);

  localparam int unsigned CntW  = $clog2(RAMP_STEPS + 2);
  localparam int unsigned DivW  = 34 + CntW;
  localparam int unsigned MulAW = rpdjt_pkg::MulAW;
  localparam int unsigned MulBW = rpdjt_pkg::MulBW;
  localparam int unsigned ProdW = rpdjt_pkg::ProdW;
  localparam int unsigned SumW  = rpdjt_pkg::SumW;
  localparam int unsigned TauW  = rpdjt_pkg::TauW;

  // Configuration registers
  logic [63:0] kp_q, kd_q, tgt_q;
  logic [15:0] signs_q, wmask_q;
  logic [30:0] jlim_q, wlim_q;

  // Sequencer and state
  rpdjt_pkg::state_e state_q, state_d;
  logic [CntW-1:0]   cnt_q;
  logic signed [31:0] start_q [16];

  // Latched sample and working registers
  logic [3:0]               idx_q;
  logic signed [31:0]       pos_q, vel_q, grav_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [SumW-1:0]   acc_q;
  logic signed [32:0]       setp_q;
  logic signed [31:0]       torque_q;
  logic                     lim_flag_q;
  logic                     out_valid_q;

  // Combinational
  logic                     in_acc, out_acc, out_free;
  logic [15:0]              kp_sel, kd_sel, tgt_sel;
  logic signed [20:0]       tgt_base, tgt_s;
  logic signed [31:0]       start_sel;
  logic signed [32:0]       diff;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  mul_p;
  logic [ProdW-1:0]         prod_mag;
  logic [DivW-1:0]          dividend;
  logic                     div_start, div_done;
  logic [DivW-1:0]          quot;
  logic signed [33:0]       q_s, setp_div;
  logic signed [SumW-1:0]   acc_rnd;
  logic signed [TauW-1:0]   tau;
  logic signed [TauW-1:0]   lim_ext;
  logic [30:0]              lim_sel;
  logic                     ramp_done;

  assign in_stall_o = (state_q != rpdjt_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ramp_done  = cnt_q >= CntW'(RAMP_STEPS);

  // Per-joint selection from the packed registers
  assign kp_sel    = kp_q[{idx_q[1:0], 4'b0000} +: 16];
  assign kd_sel    = kd_q[{idx_q[1:0], 4'b0000} +: 16];
  assign tgt_sel   = tgt_q[{idx_q[1:0], 4'b0000} +: 16];
  assign tgt_base  = 21'(signed'({tgt_sel, 4'b0000}));
  assign tgt_s     = signs_q[idx_q] ? -tgt_base : tgt_base;
  assign start_sel = start_q[idx_q];
  assign diff      = 33'(tgt_s) - 33'(start_sel);
  assign lim_sel   = wmask_q[idx_q] ? wlim_q : jlim_q;

  // Divider feed: magnitude of the ramp product plus half the divisor
  assign prod_mag = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
  assign dividend = prod_mag[DivW-1:0] + DivW'(RAMP_STEPS / 2);
  assign q_s      = signed'({1'b0, quot[32:0]});
  assign setp_div = 34'(start_sel) + (prod_q[ProdW-1] ? -q_s : q_s);

  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  // Reduce to Q16.16 with round half up, then clip
  assign acc_rnd = acc_q + SumW'(128);
  assign tau     = acc_rnd[SumW-1:8];
  assign lim_ext = TauW'(signed'({1'b0, lim_sel}));

  rpdjt_div #(
    .DW      (DivW),
    .DIVISOR (RAMP_STEPS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpdjt_pkg::ST_IDLE:    if (in_acc) state_d = rpdjt_pkg::ST_RAMP;
      rpdjt_pkg::ST_RAMP:    state_d = ramp_done ? rpdjt_pkg::ST_KP : rpdjt_pkg::ST_DIVGO;
      rpdjt_pkg::ST_DIVGO:   state_d = rpdjt_pkg::ST_DIVWAIT;
      rpdjt_pkg::ST_DIVWAIT: if (div_done) state_d = rpdjt_pkg::ST_KP;
      rpdjt_pkg::ST_KP:      state_d = rpdjt_pkg::ST_KD;
      rpdjt_pkg::ST_KD:      state_d = rpdjt_pkg::ST_SUM;
      rpdjt_pkg::ST_SUM:     state_d = rpdjt_pkg::ST_CLIP;
      rpdjt_pkg::ST_CLIP:    if (out_free) state_d = rpdjt_pkg::ST_IDLE;
      default:               state_d = rpdjt_pkg::ST_IDLE;
    endcase
  end

  // Shared multiplier operands and divider kick
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_q)
      rpdjt_pkg::ST_RAMP: begin
        mul_a = MulAW'(diff);
        mul_b = signed'({{(MulBW - CntW){1'b0}}, cnt_q});
      end
      rpdjt_pkg::ST_DIVGO: div_start = 1'b1;
      rpdjt_pkg::ST_KP: begin
        mul_a = MulAW'(setp_q) - MulAW'(pos_q);
        mul_b = signed'({1'b0, kp_sel});
      end
      rpdjt_pkg::ST_KD: begin
        mul_a = MulAW'(vel_q);
        mul_b = signed'({1'b0, kd_sel});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      kd_q    <= '0;
      tgt_q   <= '0;
      signs_q <= '0;
      jlim_q  <= rpdjt_pkg::JointLimitRst;
      wlim_q  <= rpdjt_pkg::WheelLimitRst;
      wmask_q <= rpdjt_pkg::WheelMaskRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rpdjt_pkg::CfgKpGains:    kp_q    <= cfg_data_i;
        rpdjt_pkg::CfgKdGains:    kd_q    <= cfg_data_i;
        rpdjt_pkg::CfgLegTargets: tgt_q   <= cfg_data_i;
        rpdjt_pkg::CfgJointSigns: signs_q <= cfg_data_i[15:0];
        rpdjt_pkg::CfgJointLimit: jlim_q  <= cfg_data_i[30:0];
        rpdjt_pkg::CfgWheelLimit: wlim_q  <= cfg_data_i[30:0];
        rpdjt_pkg::CfgWheelMask:  wmask_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Control state: sequencer, ramp counter, start positions, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpdjt_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        start_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_acc && enter_stance_i) begin
        start_q[joint_index_i] <= measured_position_i;
        cnt_q                  <= '0;
      end
      if (state_q == rpdjt_pkg::ST_CLIP && out_free) begin
        out_valid_q <= 1'b1;
        // advance the tick after the last joint, saturating
        if (idx_q == rpdjt_pkg::LastIdx && cnt_q < CntW'(RAMP_STEPS + 1)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q  <= joint_index_i;
      pos_q  <= measured_position_i;
      vel_q  <= measured_velocity_i;
      grav_q <= gravity_torque_i;
    end
    case (state_q)
      rpdjt_pkg::ST_RAMP: begin
        prod_q <= mul_p;
        if (ramp_done) setp_q <= 33'(tgt_s);
      end
      rpdjt_pkg::ST_DIVWAIT: if (div_done) setp_q <= setp_div[32:0];
      rpdjt_pkg::ST_KP:  prod_q <= mul_p;
      rpdjt_pkg::ST_KD: begin
        acc_q  <= (SumW'(grav_q) <<< 8) + SumW'(prod_q);
        prod_q <= mul_p;
      end
      rpdjt_pkg::ST_SUM: acc_q <= acc_q - SumW'(prod_q);
      rpdjt_pkg::ST_CLIP: begin
        if (out_free) begin
          if (tau > lim_ext) begin
            torque_q   <= signed'({1'b0, lim_sel});
            lim_flag_q <= 1'b1;
          end else if (tau < -lim_ext) begin
            torque_q   <= -signed'({1'b0, lim_sel});
            lim_flag_q <= 1'b1;
          end else begin
            torque_q   <= tau[31:0];
            lim_flag_q <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign torque_command_o = torque_q;
  assign limited_o        = lim_flag_q;

endmodule

// File: sv/rpdjt_div.sv
// Divider by a constant divisor: reciprocal multiplication, one 16-bit quotient digit at a time.
module rpdjt_div #(
  parameter int unsigned DW      = 44,
  parameter int unsigned DIVISOR = 1000
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned DigW   = 16;
  localparam int unsigned NumDig = (DW + DigW - 1) / DigW;
  localparam int unsigned PadW   = NumDig * DigW;
  localparam int unsigned LogD   = $clog2(DIVISOR);
  localparam int unsigned RemW   = (LogD == 0) ? 1 : LogD;
  localparam int unsigned TW     = RemW + DigW;
  localparam int unsigned RecW   = LogD + DigW + 1;
  localparam int unsigned PrW    = TW + RecW;
  localparam int unsigned Shift  = 2 * LogD + DigW;
  localparam int unsigned CntW   = $clog2(NumDig + 1);
  // ceil(2^Shift / DIVISOR) gives the exact floor quotient of any partial
  // dividend below DIVISOR * 2^DigW
  localparam longint unsigned RecipVal =
      ((64'd1 << Shift) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RecW-1:0] Recip = RecW'(RecipVal);

  logic [PadW-1:0] dvd_q, dvd_d;
  logic [PadW-1:0] quo_q, quo_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [PrW-1:0]  prod_q, prod_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            phase_q, phase_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [TW-1:0]   part;
  logic [DigW-1:0] digit;
  logic [TW-1:0]   part_left;

  // partial dividend: running remainder followed by the next digit
  assign part      = {rem_q, dvd_q[PadW-1 -: DigW]};
  assign digit     = prod_q[Shift +: DigW];
  assign part_left = part - TW'(digit) * TW'(DIVISOR);

  always_comb begin
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    prod_d  = prod_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      dvd_d   = PadW'(dividend_i);
      quo_d   = '0;
      rem_d   = '0;
      cnt_d   = CntW'(NumDig);
      phase_d = 1'b0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (!phase_q) begin
        prod_d  = PrW'(part) * PrW'(Recip);
        phase_d = 1'b1;
      end else begin
        // take the digit, keep the remainder, advance to the next digit
        rem_d   = part_left[RemW-1:0];
        quo_d   = (quo_q << DigW) | PadW'(digit);
        dvd_d   = dvd_q << DigW;
        phase_d = 1'b0;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[DW-1:0];

endmodule

// File: dv/tb_ramped_pd_joint_torque.sv
// Testbench for ramped_pd_joint_torque: predicts each torque word and checks it.
`timescale 1ns / 1ps

module tb_ramped_pd_joint_torque;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam longint RampSteps = rpdjt_pkg::RampStepsDefault;
  localparam logic [rpdjt_pkg::CfgIdxW-1:0] CfgUnused = 3'd7;

  typedef struct packed {
    logic signed [31:0] torque;
    logic               limited;
  } torque_word_t;

  typedef struct {
    logic [63:0] kp;
    logic [63:0] kd;
    logic [63:0] tgt;
    logic [63:0] flip;
    logic [63:0] jcap;
    logic [63:0] wcap;
    logic [63:0] wsel;
  } reg_set_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [rpdjt_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [63:0]                   cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [3:0]                    joint_index_i;
  logic                          enter_stance_i;
  logic signed [31:0]            measured_position_i;
  logic signed [31:0]            measured_velocity_i;
  logic signed [31:0]            gravity_torque_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [31:0]            torque_command_o;
  logic                          limited_o;

  // Mirror of the register file and the ramp state
  logic [63:0]        kp_set = '0;
  logic [63:0]        kd_set = '0;
  logic [63:0]        leg_target_set = '0;
  logic [15:0]        target_flip = '0;
  logic [30:0]        joint_cap = rpdjt_pkg::JointLimitRst;
  logic [30:0]        wheel_cap = rpdjt_pkg::WheelLimitRst;
  logic [15:0]        wheel_sel = rpdjt_pkg::WheelMaskRst;
  logic signed [31:0] ramp_start [16] = '{default: '0};
  longint             ramp_tick = 0;

  torque_word_t torque_q [$];
  int           mismatch_cnt = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           rx_hold_cycles = 0;
  int unsigned  cycle_cnt = 0;

  ramped_pd_joint_torque u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .joint_index_i       (joint_index_i),
    .enter_stance_i      (enter_stance_i),
    .measured_position_i (measured_position_i),
    .measured_velocity_i (measured_velocity_i),
    .gravity_torque_i    (gravity_torque_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .torque_command_o    (torque_command_o),
    .limited_o           (limited_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Work out the torque word for one accepted joint sample and advance the ramp
  function automatic torque_word_t predict_torque(input logic [3:0] idx, input logic enter,
                                                  input logic signed [31:0] pos,
                                                  input logic signed [31:0] vel,
                                                  input logic signed [31:0] grav);
    int           sub;
    longint       kp, kd, tgt, st, sp, num, sum, tau, lim;
    torque_word_t w;
    sub = idx[1:0];
    if (enter) begin
      ramp_start[idx] = pos;
      ramp_tick = 0;
    end
    kp = kp_set[16*sub +: 16];
    kd = kd_set[16*sub +: 16];
    tgt = $signed(leg_target_set[16*sub +: 16]);
    tgt = tgt * 16;
    if (target_flip[idx]) tgt = -tgt;
    st = ramp_start[idx];
    if (ramp_tick >= RampSteps) begin
      sp = tgt;
    end else begin
      // round half away from zero
      num = (tgt - st) * ramp_tick;
      if (num >= 0) sp = st + (num + RampSteps / 2) / RampSteps;
      else sp = st - (-num + RampSteps / 2) / RampSteps;
    end
    sum = longint'(grav) * 256 + kp * (sp - longint'(pos)) - kd * longint'(vel);
    tau = (sum + 128) >>> 8;
    lim = wheel_sel[idx] ? wheel_cap : joint_cap;
    w.limited = 1'b0;
    if (tau > lim) begin
      tau = lim;
      w.limited = 1'b1;
    end else if (tau < -lim) begin
      tau = -lim;
      w.limited = 1'b1;
    end
    w.torque = 32'(tau);
    if (idx == rpdjt_pkg::LastIdx && ramp_tick < RampSteps + 1) ramp_tick++;
    return w;
  endfunction

  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return ($urandom_range(1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom_range(0, 1 << 19) - (1 << 18);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(7))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [63:0] pick_cap();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return {$urandom, $urandom};
      2: return 64'h7FFF_FFFF;
      default: return {32'($urandom), 32'($urandom_range(1 << 20, 1 << 24))};
    endcase
  endfunction

  function automatic reg_set_t random_settings();
    reg_set_t s;
    int       f;
    for (f = 0; f < 4; f++) begin
      s.kp[16*f +: 16] = pick_gain();
      s.kd[16*f +: 16] = pick_gain();
      s.tgt[16*f +: 16] = ($urandom_range(7) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 16383) - 8192);
    end
    s.flip = {$urandom, $urandom};
    s.jcap = pick_cap();
    s.wcap = pick_cap();
    s.wsel = {$urandom, $urandom};
    return s;
  endfunction

  // Raise the write enable for one register; the caller drops it afterwards
  task automatic write_reg(input logic [rpdjt_pkg::CfgIdxW-1:0] index, input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (index)
      rpdjt_pkg::CfgKpGains:    kp_set = data;
      rpdjt_pkg::CfgKdGains:    kd_set = data;
      rpdjt_pkg::CfgLegTargets: leg_target_set = data;
      rpdjt_pkg::CfgJointSigns: target_flip = data[15:0];
      rpdjt_pkg::CfgJointLimit: joint_cap = data[30:0];
      rpdjt_pkg::CfgWheelLimit: wheel_cap = data[30:0];
      rpdjt_pkg::CfgWheelMask:  wheel_sel = data[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input reg_set_t s);
    write_reg(rpdjt_pkg::CfgKpGains, s.kp);
    write_reg(rpdjt_pkg::CfgKdGains, s.kd);
    write_reg(rpdjt_pkg::CfgLegTargets, s.tgt);
    write_reg(rpdjt_pkg::CfgJointSigns, s.flip);
    write_reg(rpdjt_pkg::CfgJointLimit, s.jcap);
    write_reg(rpdjt_pkg::CfgWheelLimit, s.wcap);
    write_reg(rpdjt_pkg::CfgWheelMask, s.wsel);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one joint sample and hold it until accepted
  task automatic send_joint(input logic [3:0] idx, input logic enter,
                            input logic signed [31:0] pos, input logic signed [31:0] vel,
                            input logic signed [31:0] grav);
    int gap;
    gap = 0;
    if (tx_idle_pct != 0 && $urandom_range(19) == 0) gap = $urandom_range(60);
    else while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    joint_index_i <= idx;
    enter_stance_i <= enter;
    measured_position_i <= pos;
    measured_velocity_i <= vel;
    gravity_torque_i <= grav;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    torque_q.push_back(predict_torque(idx, enter, pos, vel, grav));
  endtask

  task automatic send_random(input logic [3:0] idx, input logic enter);
    send_joint(idx, enter, pick_q16(), pick_q16(), pick_q16());
  endtask

  // Let every expected word arrive so the block is idle
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (torque_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Mostly ordered control ticks, some entry ticks, some scrambled joints
  task automatic run_ticks(input int n_items);
    int sent;
    int j;
    int kind;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        for (j = 0; j < 16; j++) send_random(4'(j), 1'b1);
        sent += 16;
      end else if (kind == 1) begin
        for (j = 0; j < 8; j++) send_random(4'($urandom_range(15)), $urandom_range(3) == 0);
        sent += 8;
      end else begin
        for (j = 0; j < 16; j++) send_random(4'(j), 1'b0);
        sent += 16;
      end
    end
  endtask

  // Zero gains after reset: torque is the gravity term, clipped per joint type
  task automatic test_reset_defaults();
    send_joint(4'd0, 1'b0, pick_q16(), pick_q16(), 32'sd0);
    send_joint(4'd0, 1'b0, pick_q16(), pick_q16(), 32'sd2293760);
    send_joint(4'd1, 1'b0, pick_q16(), pick_q16(), 32'sd2293761);
    send_joint(4'd2, 1'b0, pick_q16(), pick_q16(), -32'sd2293760);
    send_joint(4'd3, 1'b0, pick_q16(), pick_q16(), 32'sd150 <<< 16);
    send_joint(4'd8, 1'b0, pick_q16(), pick_q16(), -(32'sd300 <<< 16));
    send_joint(4'd13, 1'b0, pick_q16(), pick_q16(), 32'sh7FFF_FFFF);
    send_joint(4'd5, 1'b0, pick_q16(), pick_q16(), 32'sh8000_0000);
  endtask

  // Full-scale gains and fields, rounding ties on both signs, ignored register index
  task automatic test_field_extremes();
    reg_set_t s;
    drain_block();
    s.kp = '1;
    s.kd = '1;
    s.tgt = {16'h7FFF, 16'h0001, 16'h8000, 16'hFFFF};
    s.flip = 64'hA5A5;
    s.jcap = '1;
    s.wcap = 64'h0;
    s.wsel = 64'h8080;
    write_reg(CfgUnused, '1);
    load_settings(s);
    send_joint(4'd0, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_joint(4'd1, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_joint(4'd3, 1'b0, -32'sd1, 32'sd1, -32'sd1);
    send_joint(4'd2, 1'b1, -32'sd516, 32'sd0, 32'sd0);
    send_joint(4'd6, 1'b1, 32'sd516, 32'sd0, 32'sd0);
    send_joint(4'd15, 1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_joint(4'd2, 1'b0, 32'sd0, 32'sd0, 32'sd0);
    send_joint(4'd6, 1'b0, 32'sd0, 32'sd0, 32'sd0);
    send_joint(4'd0, 1'b0, 32'sd0, 32'sd0, 32'sd0);
    send_random(4'd9, 1'b0);
  endtask

  task automatic test_random_ticks(input int n_sets, input int per_set);
    int k;
    for (k = 0; k < n_sets; k++) begin
      drain_block();
      load_settings(random_settings());
      run_ticks(per_set);
    end
  endtask

  // Hold the output long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    int j;
    drain_block();
    rx_hold_cycles = 400;
    for (j = 0; j < 12; j++) send_random(4'($urandom_range(15)), 1'b0);
  endtask

  // Walk the ramp counter through every step into saturation
  task automatic test_ramp_to_hold();
    reg_set_t s;
    int       n;
    int       j;
    drain_block();
    s = random_settings();
    // keep the setpoint visible through the torque
    s.jcap = 64'h7FFF_FFFF;
    s.wcap = 64'h7FFF_FFFF;
    load_settings(s);
    for (j = 0; j < 16; j++) send_random(4'(j), 1'b1);
    for (n = 0; n < 1004; n++) begin
      if (n == 500) begin
        drain_block();
        s.tgt = {$urandom, $urandom};
        load_settings(s);
      end
      send_random(4'd15, 1'b0);
      if (n % 40 == 0) send_random(4'($urandom_range(14)), 1'b0);
    end
    for (j = 0; j < 32; j++) send_random(4'(j % 16), 1'b0);
  endtask

  initial begin : rx_throttle
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        while (rx_hold_cycles != 0) begin
          @(posedge clk_i);
          rx_hold_cycles--;
        end
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    torque_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (torque_q.size() == 0) begin
        $display("%0t: unexpected word torque_command %0d limited %0b",
                 $time, torque_command_o, limited_o);
        mismatch_cnt++;
      end else begin
        want = torque_q.pop_front();
        if (torque_command_o !== want.torque) begin
          $display("%0t: torque_command expected %0d got %0d",
                   $time, want.torque, torque_command_o);
          mismatch_cnt++;
        end
        if (limited_o !== want.limited) begin
          $display("%0t: limited expected %0b got %0b", $time, want.limited, limited_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : main_seq
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    joint_index_i <= '0;
    enter_stance_i <= 1'b0;
    measured_position_i <= '0;
    measured_velocity_i <= '0;
    gravity_torque_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 13;
    rx_idle_pct = 73;
    test_reset_defaults();
    test_field_extremes();
    test_random_ticks(3, 60);

    tx_idle_pct = 73;
    rx_idle_pct = 13;
    test_random_ticks(3, 60);
    test_output_backpressure();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_ramp_to_hold();
    test_random_ticks(2, 40);

    drain_block();
    repeat (60) @(posedge clk_i);
    if (mismatch_cnt == 0 && torque_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/rpdjt_pkg.sv
sv/rpdjt_div.sv
sv/ramped_pd_joint_torque.sv
dv/tb_ramped_pd_joint_torque.sv
